// File: sv/cpu65816_instruction_predecoder_top_macros.svh
// Assertion macros for the 65816 instruction predecoder.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef CPU65816_INSTRUCTION_PREDECODER_TOP_MACROS_SVH
`define CPU65816_INSTRUCTION_PREDECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define C816PD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("predecoder same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define C816PD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("predecoder next-cycle check failed");

`endif

// File: sv/c816pd_pkg.sv
// Package for the 65816 instruction predecoder: opcodes, class codes,
// the instruction length table and the operation class table. No dependencies.
`timescale 1ns / 1ps

package c816pd_pkg;

	localparam int ADDR_BITS = 24;

	typedef enum logic [4:0] {
		CLS_UNKNOWN  = 5'd0,
		CLS_NOP      = 5'd1,
		CLS_XCHG     = 5'd2,
		CLS_SWI      = 5'd3,
		CLS_MOV      = 5'd4,
		CLS_PUSH     = 5'd5,
		CLS_POP      = 5'd6,
		CLS_ADD      = 5'd7,
		CLS_AND      = 5'd8,
		CLS_BITTEST  = 5'd9,
		CLS_CMP      = 5'd10,
		CLS_OR       = 5'd11,
		CLS_XOR      = 5'd12,
		CLS_SHL      = 5'd13,
		CLS_SHR      = 5'd14,
		CLS_ROL      = 5'd15,
		CLS_ROR      = 5'd16,
		CLS_SUB      = 5'd17,
		CLS_STORE    = 5'd18,
		CLS_LOAD     = 5'd19,
		CLS_JMP      = 5'd20,
		CLS_IJMP     = 5'd21,
		CLS_CJMP     = 5'd22,
		CLS_CALL     = 5'd23,
		CLS_ICALL    = 5'd24,
		CLS_RET      = 5'd25
	} op_class_t;

	typedef enum logic [1:0] {
		COND_NONE  = 2'd0,
		COND_EQ    = 2'd1,
		COND_NE    = 2'd2
	} branch_cond_t;

	localparam logic [7:0] OPC_JMP_ABS  = 8'h4C;
	localparam logic [7:0] OPC_JSR_ABS  = 8'h20;
	localparam logic [7:0] OPC_JML_LONG = 8'h5C;
	localparam logic [7:0] OPC_JSL_LONG = 8'h22;
	localparam logic [7:0] OPC_BRA      = 8'h80;
	localparam logic [7:0] OPC_BRL      = 8'h82;
	localparam logic [7:0] OPC_BPL      = 8'h10;
	localparam logic [7:0] OPC_BMI      = 8'h30;
	localparam logic [7:0] OPC_BVC      = 8'h50;
	localparam logic [7:0] OPC_BVS      = 8'h70;
	localparam logic [7:0] OPC_BCC      = 8'h90;
	localparam logic [7:0] OPC_BCS      = 8'hB0;
	localparam logic [7:0] OPC_BNE      = 8'hD0;
	localparam logic [7:0] OPC_BEQ      = 8'hF0;
	localparam logic [7:0] OPC_REP      = 8'hC2;
	localparam logic [7:0] OPC_SEP      = 8'hE2;

	localparam logic [7:0] OPC_ORA_IMM  = 8'h09;
	localparam logic [7:0] OPC_AND_IMM  = 8'h29;
	localparam logic [7:0] OPC_EOR_IMM  = 8'h49;
	localparam logic [7:0] OPC_ADC_IMM  = 8'h69;
	localparam logic [7:0] OPC_BIT_IMM  = 8'h89;
	localparam logic [7:0] OPC_LDA_IMM  = 8'hA9;
	localparam logic [7:0] OPC_CMP_IMM  = 8'hC9;
	localparam logic [7:0] OPC_SBC_IMM  = 8'hE9;
	localparam logic [7:0] OPC_LDY_IMM  = 8'hA0;
	localparam logic [7:0] OPC_LDX_IMM  = 8'hA2;
	localparam logic [7:0] OPC_CPY_IMM  = 8'hC0;
	localparam logic [7:0] OPC_CPX_IMM  = 8'hE0;

	localparam int FLAG_X_BIT = 4;
	localparam int FLAG_M_BIT = 5;

	localparam logic [2:0] LEN_TAB [256] = '{
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd3,3'd2,3'd4,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd1,3'd2,3'd2,3'd2,3'd3,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd3,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd4,3'd3,3'd3,3'd4,
		3'd1,3'd2,3'd3,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd3,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd1,3'd2,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4,
		3'd2,3'd2,3'd2,3'd2,3'd3,3'd2,3'd2,3'd2,3'd1,3'd3,3'd1,3'd1,3'd3,3'd3,3'd3,3'd4
	};

	localparam logic [4:0] CLASS_TAB [256] = '{
		5'd3,5'd11,5'd3,5'd11,5'd0,5'd11,5'd13,5'd11,
		5'd5,5'd11,5'd13,5'd5,5'd0,5'd11,5'd13,5'd11,
		5'd22,5'd11,5'd11,5'd11,5'd0,5'd11,5'd13,5'd11,
		5'd0,5'd11,5'd7,5'd4,5'd0,5'd11,5'd13,5'd11,
		5'd23,5'd8,5'd23,5'd8,5'd9,5'd8,5'd15,5'd8,
		5'd6,5'd8,5'd15,5'd6,5'd9,5'd8,5'd15,5'd8,
		5'd22,5'd8,5'd8,5'd8,5'd9,5'd8,5'd15,5'd8,
		5'd0,5'd8,5'd17,5'd4,5'd9,5'd8,5'd15,5'd8,
		5'd25,5'd12,5'd0,5'd12,5'd0,5'd12,5'd14,5'd12,
		5'd5,5'd12,5'd14,5'd5,5'd20,5'd12,5'd14,5'd12,
		5'd22,5'd12,5'd12,5'd12,5'd0,5'd12,5'd14,5'd12,
		5'd0,5'd12,5'd5,5'd4,5'd20,5'd12,5'd14,5'd12,
		5'd25,5'd7,5'd0,5'd7,5'd18,5'd7,5'd16,5'd7,
		5'd6,5'd7,5'd16,5'd25,5'd21,5'd7,5'd16,5'd7,
		5'd22,5'd7,5'd7,5'd7,5'd18,5'd7,5'd16,5'd7,
		5'd0,5'd7,5'd6,5'd4,5'd21,5'd7,5'd16,5'd7,
		5'd20,5'd18,5'd20,5'd18,5'd18,5'd18,5'd18,5'd18,
		5'd17,5'd9,5'd4,5'd5,5'd18,5'd18,5'd18,5'd18,
		5'd22,5'd18,5'd18,5'd18,5'd18,5'd18,5'd18,5'd18,
		5'd4,5'd18,5'd4,5'd4,5'd18,5'd18,5'd18,5'd18,
		5'd19,5'd19,5'd19,5'd19,5'd19,5'd19,5'd19,5'd19,
		5'd4,5'd19,5'd4,5'd6,5'd19,5'd19,5'd19,5'd19,
		5'd22,5'd19,5'd19,5'd19,5'd19,5'd19,5'd19,5'd19,
		5'd0,5'd19,5'd4,5'd4,5'd19,5'd19,5'd19,5'd19,
		5'd10,5'd10,5'd0,5'd10,5'd10,5'd10,5'd17,5'd10,
		5'd7,5'd10,5'd17,5'd0,5'd10,5'd10,5'd17,5'd10,
		5'd22,5'd10,5'd10,5'd10,5'd0,5'd10,5'd17,5'd10,
		5'd0,5'd10,5'd5,5'd0,5'd21,5'd10,5'd17,5'd10,
		5'd10,5'd17,5'd0,5'd17,5'd10,5'd17,5'd7,5'd17,
		5'd7,5'd17,5'd1,5'd0,5'd10,5'd17,5'd7,5'd17,
		5'd22,5'd17,5'd17,5'd17,5'd0,5'd17,5'd7,5'd17,
		5'd0,5'd17,5'd6,5'd2,5'd24,5'd17,5'd7,5'd17
	};

endpackage

// File: sv/cpu65816_instruction_predecoder_top.sv
// Top level of the 65816 instruction predecoder.
// Depends on c816pd_pkg and cpu65816_instruction_predecoder_top_macros.svh.
// An accepted beat passes the input stage register, then the result register.
// Throughput is one instruction per cycle unless out_ready stalls; the decode
// is length and class lookups and target adders between those registers.
// Reset clears both stage valids and the M and X flags (16-bit widths).
`timescale 1ns / 1ps

`include "cpu65816_instruction_predecoder_top_macros.svh"

module cpu65816_instruction_predecoder_top #(
	parameter int ADDRESS_BITS = c816pd_pkg::ADDR_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              opcode,
	input  logic [7:0]              operand_lo,
	input  logic [7:0]              operand_mid,
	input  logic [7:0]              operand_hi,
	input  logic [ADDRESS_BITS-1:0] pc_address,
	input  logic [2:0]              bytes_available,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              insn_size,
	output logic [4:0]              op_class,
	output logic                    ends_block,
	output logic                    has_target,
	output logic [ADDRESS_BITS-1:0] jump_target,
	output logic                    has_fallthrough,
	output logic [ADDRESS_BITS-1:0] fallthrough_target,
	output logic [1:0]              branch_condition
);
	import c816pd_pkg::*;

	logic                    valid_s1;
	logic [7:0]              opcode_s1;
	logic [7:0]              lo_s1;
	logic [7:0]              mid_s1;
	logic [7:0]              hi_s1;
	logic [ADDRESS_BITS-1:0] pc_s1;
	logic [2:0]              avail_s1;

	logic acc_narrow_q;
	logic index_narrow_q;

	logic                    out_valid_q;
	logic [2:0]              size_q;
	logic [4:0]              class_q;
	logic                    ends_q;
	logic                    has_tgt_q;
	logic [ADDRESS_BITS-1:0] tgt_q;
	logic                    has_fall_q;
	logic [ADDRESS_BITS-1:0] fall_q;
	logic [1:0]              cond_q;

	logic                    in_fire;
	logic                    advance;
	logic                    widen;
	logic [2:0]              size_d;
	logic                    fits;
	op_class_t               class_d;
	logic                    ends_d;
	logic                    has_tgt_d;
	logic [ADDRESS_BITS-1:0] tgt_d;
	logic                    has_fall_d;
	logic [ADDRESS_BITS-1:0] fall_d;
	branch_cond_t            cond_d;
	logic [ADDRESS_BITS-1:0] rel8;
	logic [ADDRESS_BITS-1:0] rel16;
	logic                    acc_narrow_d;
	logic                    index_narrow_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1 <= opcode;
			lo_s1     <= operand_lo;
			mid_s1    <= operand_mid;
			hi_s1     <= operand_hi;
			pc_s1     <= pc_address;
			avail_s1  <= bytes_available;
		end
	end

	always_comb begin
		unique case (opcode_s1) inside
			OPC_ORA_IMM, OPC_AND_IMM, OPC_EOR_IMM, OPC_ADC_IMM,
			OPC_BIT_IMM, OPC_LDA_IMM, OPC_CMP_IMM, OPC_SBC_IMM: begin
				widen = !acc_narrow_q;
			end
			OPC_LDY_IMM, OPC_LDX_IMM, OPC_CPY_IMM, OPC_CPX_IMM: begin
				widen = !index_narrow_q;
			end
			default: begin
				widen = 1'b0;
			end
		endcase
	end

	assign size_d  = LEN_TAB[opcode_s1] + {2'b00, widen};
	assign fits    = size_d <= avail_s1;
	assign class_d = op_class_t'(CLASS_TAB[opcode_s1]);
	assign ends_d  = (class_d == CLS_JMP) || (class_d == CLS_IJMP) ||
		(class_d == CLS_CJMP) || (class_d == CLS_RET);
	assign rel8    = {{(ADDRESS_BITS-8){lo_s1[7]}}, lo_s1};
	assign rel16   = {{(ADDRESS_BITS-16){mid_s1[7]}}, mid_s1, lo_s1};

	always_comb begin
		has_tgt_d      = 1'b0;
		tgt_d          = '0;
		has_fall_d     = 1'b0;
		fall_d         = '0;
		cond_d         = COND_NONE;
		acc_narrow_d   = acc_narrow_q;
		index_narrow_d = index_narrow_q;
		unique case (opcode_s1) inside
			OPC_JMP_ABS, OPC_JSR_ABS: begin
				has_tgt_d = 1'b1;
				tgt_d     = {pc_s1[ADDRESS_BITS-1:16], mid_s1, lo_s1};
			end
			OPC_JML_LONG, OPC_JSL_LONG: begin
				has_tgt_d = 1'b1;
				tgt_d     = ADDRESS_BITS'({hi_s1, mid_s1, lo_s1});
			end
			OPC_BRA: begin
				has_tgt_d = 1'b1;
				tgt_d     = pc_s1 + ADDRESS_BITS'(2) + rel8;
			end
			OPC_BRL: begin
				has_tgt_d = 1'b1;
				tgt_d     = pc_s1 + ADDRESS_BITS'(3) + rel16;
			end
			OPC_BPL, OPC_BMI, OPC_BVC, OPC_BVS,
			OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ: begin
				has_tgt_d  = 1'b1;
				has_fall_d = 1'b1;
				tgt_d      = pc_s1 + ADDRESS_BITS'(2) + rel8;
				fall_d     = pc_s1 + ADDRESS_BITS'(2);
				if (opcode_s1 == OPC_BNE) begin
					cond_d = COND_NE;
				end else if (opcode_s1 == OPC_BEQ) begin
					cond_d = COND_EQ;
				end
			end
			OPC_REP: begin
				if (lo_s1[FLAG_X_BIT]) begin
					index_narrow_d = 1'b0;
				end
				if (lo_s1[FLAG_M_BIT]) begin
					acc_narrow_d = 1'b0;
				end
			end
			OPC_SEP: begin
				if (lo_s1[FLAG_X_BIT]) begin
					index_narrow_d = 1'b1;
				end
				if (lo_s1[FLAG_M_BIT]) begin
					acc_narrow_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_narrow_q   <= 1'b0;
			index_narrow_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance && fits) begin
				acc_narrow_q   <= acc_narrow_d;
				index_narrow_q <= index_narrow_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (fits) begin
				size_q     <= size_d;
				class_q    <= class_d;
				ends_q     <= ends_d;
				has_tgt_q  <= has_tgt_d;
				tgt_q      <= tgt_d;
				has_fall_q <= has_fall_d;
				fall_q     <= fall_d;
				cond_q     <= cond_d;
			end else begin
				size_q     <= '0;
				class_q    <= CLS_UNKNOWN;
				ends_q     <= 1'b0;
				has_tgt_q  <= 1'b0;
				tgt_q      <= '0;
				has_fall_q <= 1'b0;
				fall_q     <= '0;
				cond_q     <= COND_NONE;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign insn_size          = size_q;
	assign op_class           = class_q;
	assign ends_block         = ends_q;
	assign has_target         = has_tgt_q;
	assign jump_target        = tgt_q;
	assign has_fallthrough    = has_fall_q;
	assign fallthrough_target = fall_q;
	assign branch_condition   = cond_q;

	`C816PD_ASSERT_NOW(a_trunc_zero, out_valid_q && (size_q == 3'd0),
		(class_q == CLS_UNKNOWN) && !has_tgt_q && !has_fall_q && (cond_q == COND_NONE))
	`C816PD_ASSERT_NOW(a_fall_needs_tgt, out_valid_q && has_fall_q,
		has_tgt_q && ends_q && (class_q == CLS_CJMP))
	`C816PD_ASSERT_NOW(a_no_tgt_zero, out_valid_q && !has_tgt_q, tgt_q == '0)
	`C816PD_ASSERT_NEXT(a_flags_hold,
		!(advance && fits && ((opcode_s1 == OPC_REP) || (opcode_s1 == OPC_SEP))),
		$stable(acc_narrow_q) && $stable(index_narrow_q))

endmodule

// File: tb/sv/cpu65816_instruction_predecoder_checker.sv
// Scoreboard for the 65816 instruction predecoder: watches both channels, predicts each decode
// from its own copy of the M and X width flags and compares every result beat field by field.
// Depends on c816pd_pkg for the class and condition enums and the opcode names.
`timescale 1ns / 1ps

module cpu65816_instruction_predecoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [7:0]                      opcode,
	input  logic [7:0]                      operand_lo,
	input  logic [7:0]                      operand_mid,
	input  logic [7:0]                      operand_hi,
	input  logic [c816pd_pkg::ADDR_BITS-1:0] pc_address,
	input  logic [2:0]                      bytes_available,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [2:0]                      insn_size,
	input  logic [4:0]                      op_class,
	input  logic                            ends_block,
	input  logic                            has_target,
	input  logic [c816pd_pkg::ADDR_BITS-1:0] jump_target,
	input  logic                            has_fallthrough,
	input  logic [c816pd_pkg::ADDR_BITS-1:0] fallthrough_target,
	input  logic [1:0]                      branch_condition,
	output int                              mismatch_count,
	output int                              pending_count
);
	import c816pd_pkg::*;

	typedef struct packed {
		logic [2:0]           size;
		op_class_t            cls;
		logic                 ends;
		logic                 has_tgt;
		logic [ADDR_BITS-1:0] tgt;
		logic                 has_fall;
		logic [ADDR_BITS-1:0] fall;
		branch_cond_t         cond;
	} decode_t;

	localparam int INSN_LEN [256] = '{
		2,2,2,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		3,2,4,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		1,2,2,2,3,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,3,2,2,2,1,3,1,1,4,3,3,4,
		1,2,3,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		2,2,3,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,3,1,1,3,3,3,4,
		2,2,2,2,2,2,2,2,1,2,1,1,3,3,3,4,
		2,2,2,2,3,2,2,2,1,3,1,1,3,3,3,4
	};

	localparam op_class_t INSN_CLASS [256] = '{
		CLS_SWI, CLS_OR, CLS_SWI, CLS_OR, CLS_UNKNOWN, CLS_OR, CLS_SHL, CLS_OR,
		CLS_PUSH, CLS_OR, CLS_SHL, CLS_PUSH, CLS_UNKNOWN, CLS_OR, CLS_SHL, CLS_OR,
		CLS_CJMP, CLS_OR, CLS_OR, CLS_OR, CLS_UNKNOWN, CLS_OR, CLS_SHL, CLS_OR,
		CLS_UNKNOWN, CLS_OR, CLS_ADD, CLS_MOV, CLS_UNKNOWN, CLS_OR, CLS_SHL, CLS_OR,
		CLS_CALL, CLS_AND, CLS_CALL, CLS_AND, CLS_BITTEST, CLS_AND, CLS_ROL, CLS_AND,
		CLS_POP, CLS_AND, CLS_ROL, CLS_POP, CLS_BITTEST, CLS_AND, CLS_ROL, CLS_AND,
		CLS_CJMP, CLS_AND, CLS_AND, CLS_AND, CLS_BITTEST, CLS_AND, CLS_ROL, CLS_AND,
		CLS_UNKNOWN, CLS_AND, CLS_SUB, CLS_MOV, CLS_BITTEST, CLS_AND, CLS_ROL, CLS_AND,
		CLS_RET, CLS_XOR, CLS_UNKNOWN, CLS_XOR, CLS_UNKNOWN, CLS_XOR, CLS_SHR, CLS_XOR,
		CLS_PUSH, CLS_XOR, CLS_SHR, CLS_PUSH, CLS_JMP, CLS_XOR, CLS_SHR, CLS_XOR,
		CLS_CJMP, CLS_XOR, CLS_XOR, CLS_XOR, CLS_UNKNOWN, CLS_XOR, CLS_SHR, CLS_XOR,
		CLS_UNKNOWN, CLS_XOR, CLS_PUSH, CLS_MOV, CLS_JMP, CLS_XOR, CLS_SHR, CLS_XOR,
		CLS_RET, CLS_ADD, CLS_UNKNOWN, CLS_ADD, CLS_STORE, CLS_ADD, CLS_ROR, CLS_ADD,
		CLS_POP, CLS_ADD, CLS_ROR, CLS_RET, CLS_IJMP, CLS_ADD, CLS_ROR, CLS_ADD,
		CLS_CJMP, CLS_ADD, CLS_ADD, CLS_ADD, CLS_STORE, CLS_ADD, CLS_ROR, CLS_ADD,
		CLS_UNKNOWN, CLS_ADD, CLS_POP, CLS_MOV, CLS_IJMP, CLS_ADD, CLS_ROR, CLS_ADD,
		CLS_JMP, CLS_STORE, CLS_JMP, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE,
		CLS_SUB, CLS_BITTEST, CLS_MOV, CLS_PUSH, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE,
		CLS_CJMP, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE,
		CLS_MOV, CLS_STORE, CLS_MOV, CLS_MOV, CLS_STORE, CLS_STORE, CLS_STORE, CLS_STORE,
		CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD,
		CLS_MOV, CLS_LOAD, CLS_MOV, CLS_POP, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD,
		CLS_CJMP, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD,
		CLS_UNKNOWN, CLS_LOAD, CLS_MOV, CLS_MOV, CLS_LOAD, CLS_LOAD, CLS_LOAD, CLS_LOAD,
		CLS_CMP, CLS_CMP, CLS_UNKNOWN, CLS_CMP, CLS_CMP, CLS_CMP, CLS_SUB, CLS_CMP,
		CLS_ADD, CLS_CMP, CLS_SUB, CLS_UNKNOWN, CLS_CMP, CLS_CMP, CLS_SUB, CLS_CMP,
		CLS_CJMP, CLS_CMP, CLS_CMP, CLS_CMP, CLS_UNKNOWN, CLS_CMP, CLS_SUB, CLS_CMP,
		CLS_UNKNOWN, CLS_CMP, CLS_PUSH, CLS_UNKNOWN, CLS_IJMP, CLS_CMP, CLS_SUB, CLS_CMP,
		CLS_CMP, CLS_SUB, CLS_UNKNOWN, CLS_SUB, CLS_CMP, CLS_SUB, CLS_ADD, CLS_SUB,
		CLS_ADD, CLS_SUB, CLS_NOP, CLS_UNKNOWN, CLS_CMP, CLS_SUB, CLS_ADD, CLS_SUB,
		CLS_CJMP, CLS_SUB, CLS_SUB, CLS_SUB, CLS_UNKNOWN, CLS_SUB, CLS_ADD, CLS_SUB,
		CLS_UNKNOWN, CLS_SUB, CLS_POP, CLS_XCHG, CLS_ICALL, CLS_SUB, CLS_ADD, CLS_SUB
	};

	logic    acc_narrow;
	logic    index_narrow;
	decode_t decodes_due [$];
	decode_t want;
	decode_t got;

	task automatic decode_insn(input logic [7:0] op, input logic [7:0] lo,
			input logic [7:0] mid, input logic [7:0] hi,
			input logic [ADDR_BITS-1:0] pc, input logic [2:0] avail, output decode_t d);
		int len;
		d = '0;
		len = INSN_LEN[op];
		case (op)
			OPC_ORA_IMM, OPC_AND_IMM, OPC_EOR_IMM, OPC_ADC_IMM,
			OPC_BIT_IMM, OPC_LDA_IMM, OPC_CMP_IMM, OPC_SBC_IMM: begin
				if (!acc_narrow)
					len = len + 1;
			end
			OPC_LDY_IMM, OPC_LDX_IMM, OPC_CPY_IMM, OPC_CPX_IMM: begin
				if (!index_narrow)
					len = len + 1;
			end
			default: ;
		endcase
		if (len <= avail) begin
			d.size = 3'(len);
			d.cls  = INSN_CLASS[op];
			d.ends = (d.cls == CLS_JMP) || (d.cls == CLS_IJMP) || (d.cls == CLS_CJMP)
				|| (d.cls == CLS_RET);
			case (op)
				OPC_JMP_ABS, OPC_JSR_ABS: begin
					d.has_tgt = 1'b1;
					d.tgt = {pc[ADDR_BITS-1 -: 8], mid, lo};
				end
				OPC_JML_LONG, OPC_JSL_LONG: begin
					d.has_tgt = 1'b1;
					d.tgt = {hi, mid, lo};
				end
				OPC_BRA: begin
					d.has_tgt = 1'b1;
					d.tgt = pc + ADDR_BITS'(2) + {{(ADDR_BITS-8){lo[7]}}, lo};
				end
				OPC_BRL: begin
					d.has_tgt = 1'b1;
					d.tgt = pc + ADDR_BITS'(3) + {{(ADDR_BITS-16){mid[7]}}, mid, lo};
				end
				OPC_BPL, OPC_BMI, OPC_BVC, OPC_BVS, OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ: begin
					d.has_tgt  = 1'b1;
					d.tgt      = pc + ADDR_BITS'(2) + {{(ADDR_BITS-8){lo[7]}}, lo};
					d.has_fall = 1'b1;
					d.fall     = pc + ADDR_BITS'(2);
					if (op == OPC_BNE)
						d.cond = COND_NE;
					else if (op == OPC_BEQ)
						d.cond = COND_EQ;
				end
				OPC_REP: begin
					if (lo[FLAG_X_BIT])
						index_narrow = 1'b0;
					if (lo[FLAG_M_BIT])
						acc_narrow = 1'b0;
				end
				OPC_SEP: begin
					if (lo[FLAG_X_BIT])
						index_narrow = 1'b1;
					if (lo[FLAG_M_BIT])
						acc_narrow = 1'b1;
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [ADDR_BITS-1:0] exp_val,
			input logic [ADDR_BITS-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decodes_due.delete();
			acc_narrow     = 1'b0;
			index_narrow   = 1'b0;
			pending_count  = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decodes_due.size() == 0) begin
					$error("result beat with no instruction outstanding");
					mismatch_count++;
				end else begin
					want = decodes_due.pop_front();
					check_field("insn_size", ADDR_BITS'(want.size), ADDR_BITS'(insn_size));
					check_field("op_class", ADDR_BITS'(want.cls), ADDR_BITS'(op_class));
					check_field("ends_block", ADDR_BITS'(want.ends), ADDR_BITS'(ends_block));
					check_field("has_target", ADDR_BITS'(want.has_tgt),
						ADDR_BITS'(has_target));
					check_field("jump_target", want.tgt, jump_target);
					check_field("has_fallthrough", ADDR_BITS'(want.has_fall),
						ADDR_BITS'(has_fallthrough));
					check_field("fallthrough_target", want.fall, fallthrough_target);
					check_field("branch_condition", ADDR_BITS'(want.cond),
						ADDR_BITS'(branch_condition));
				end
			end
			if (in_valid && in_ready) begin
				decode_insn(opcode, operand_lo, operand_mid, operand_hi, pc_address,
					bytes_available, got);
				decodes_due.push_back(got);
			end
			pending_count = decodes_due.size();
		end
	end

endmodule

// File: tb/sv/cpu65816_instruction_predecoder_top_test.sv
// Testbench top for the 65816 instruction predecoder: drives directed and random instruction
// beats under varying idle patterns and back-pressure, and reports the verdict.
// Depends on c816pd_pkg, the predecoder RTL and cpu65816_instruction_predecoder_checker.
`timescale 1ns / 1ps

module cpu65816_instruction_predecoder_top_test;
	import c816pd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 217;
	localparam int LONG_HOLD    = 96;

	localparam logic [7:0] OPC_BRK      = 8'h00;
	localparam logic [7:0] OPC_AND_DPX  = 8'h21;
	localparam logic [7:0] OPC_WDM      = 8'h42;
	localparam logic [7:0] OPC_RTS      = 8'h60;
	localparam logic [7:0] OPC_JMP_IND  = 8'h6C;
	localparam logic [7:0] OPC_JSR_INDX = 8'hFC;
	localparam logic [7:0] OPC_SBC_LNGX = 8'hFF;

	localparam logic [7:0] FLOW_OPS [14] = '{
		OPC_JMP_ABS, OPC_JSR_ABS, OPC_JML_LONG, OPC_JSL_LONG, OPC_BRA, OPC_BRL, OPC_BPL,
		OPC_BMI, OPC_BVC, OPC_BVS, OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ
	};
	localparam logic [7:0] IMM_OPS [12] = '{
		OPC_ORA_IMM, OPC_AND_IMM, OPC_EOR_IMM, OPC_ADC_IMM, OPC_BIT_IMM, OPC_LDA_IMM,
		OPC_CMP_IMM, OPC_SBC_IMM, OPC_LDY_IMM, OPC_LDX_IMM, OPC_CPY_IMM, OPC_CPX_IMM
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           opcode;
	logic [7:0]           operand_lo;
	logic [7:0]           operand_mid;
	logic [7:0]           operand_hi;
	logic [ADDR_BITS-1:0] pc_address;
	logic [2:0]           bytes_available;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           insn_size;
	logic [4:0]           op_class;
	logic                 ends_block;
	logic                 has_target;
	logic [ADDR_BITS-1:0] jump_target;
	logic                 has_fallthrough;
	logic [ADDR_BITS-1:0] fallthrough_target;
	logic [1:0]           branch_condition;

	int mismatch_count;
	int pending_count;
	int cycle_count   = 0;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int hold_left     = 0;
	bit long_hold_req = 1'b0;

	always #6 clk = ~clk;

	cpu65816_instruction_predecoder_top u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.opcode             (opcode),
		.operand_lo         (operand_lo),
		.operand_mid        (operand_mid),
		.operand_hi         (operand_hi),
		.pc_address         (pc_address),
		.bytes_available    (bytes_available),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.insn_size          (insn_size),
		.op_class           (op_class),
		.ends_block         (ends_block),
		.has_target         (has_target),
		.jump_target        (jump_target),
		.has_fallthrough    (has_fallthrough),
		.fallthrough_target (fallthrough_target),
		.branch_condition   (branch_condition)
	);

	cpu65816_instruction_predecoder_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.opcode             (opcode),
		.operand_lo         (operand_lo),
		.operand_mid        (operand_mid),
		.operand_hi         (operand_hi),
		.pc_address         (pc_address),
		.bytes_available    (bytes_available),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.insn_size          (insn_size),
		.op_class           (op_class),
		.ends_block         (ends_block),
		.has_target         (has_target),
		.jump_target        (jump_target),
		.has_fallthrough    (has_fallthrough),
		.fallthrough_target (fallthrough_target),
		.branch_condition   (branch_condition),
		.mismatch_count     (mismatch_count),
		.pending_count      (pending_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The receiver counts a long hold-off itself once asked, so the sender keeps offering beats.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_insn(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] mid,
			input logic [7:0] hi, input logic [ADDR_BITS-1:0] pc, input logic [2:0] avail);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= op;
		operand_lo      <= lo;
		operand_mid     <= mid;
		operand_hi      <= hi;
		pc_address      <= pc;
		bytes_available <= avail;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random_insn();
		logic [7:0]           op;
		logic [ADDR_BITS-1:0] pc;
		logic [2:0]           avail;
		int                   pick;
		pick = $urandom_range(99);
		if (pick < 12)
			op = $urandom_range(1) ? OPC_REP : OPC_SEP;
		else if (pick < 35)
			op = FLOW_OPS[$urandom_range(13)];
		else if (pick < 50)
			op = IMM_OPS[$urandom_range(11)];
		else
			op = 8'($urandom_range(255));
		case ($urandom_range(9))
			0: pc = ADDR_BITS'($urandom_range(255));
			1: pc = {ADDR_BITS{1'b1}} - ADDR_BITS'($urandom_range(255));
			default: pc = ADDR_BITS'($urandom);
		endcase
		avail = ($urandom_range(99) < 80) ? 3'd4 : 3'($urandom_range(3));
		send_insn(op, 8'($urandom), 8'($urandom), 8'($urandom), pc, avail);
	endtask

	task automatic drain_decodes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		opcode          = '0;
		operand_lo      = '0;
		operand_mid     = '0;
		operand_hi      = '0;
		pc_address      = '0;
		bytes_available = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_insn(OPC_BRK, 8'h00, 8'h00, 8'h00, 24'h000000, 3'd0);
		send_insn(OPC_SBC_LNGX, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 3'd4);
		send_insn(OPC_LDA_IMM, 8'h34, 8'h12, 8'h00, 24'h008000, 3'd3);
		send_insn(OPC_LDA_IMM, 8'h34, 8'h12, 8'h00, 24'h008003, 3'd2);
		send_insn(OPC_LDX_IMM, 8'h01, 8'h02, 8'h03, 24'h008003, 3'd2);
		send_insn(OPC_SEP, 8'h30, 8'h00, 8'h00, 24'h008003, 3'd2);
		send_insn(OPC_LDA_IMM, 8'hAA, 8'h55, 8'h00, 24'h008005, 3'd2);
		send_insn(OPC_CPX_IMM, 8'h7F, 8'h80, 8'h00, 24'h008007, 3'd2);
		send_insn(OPC_REP, 8'h10, 8'h00, 8'h00, 24'h008009, 3'd4);
		send_insn(OPC_CPY_IMM, 8'h00, 8'h00, 8'h00, 24'h00800B, 3'd2);
		send_insn(OPC_ADC_IMM, 8'h01, 8'h00, 8'h00, 24'h00800B, 3'd2);
		send_insn(OPC_REP, 8'hEF, 8'h00, 8'h00, 24'h00800D, 3'd4);
		send_insn(OPC_SEP, 8'hFF, 8'h00, 8'h00, 24'h00800F, 3'd1);
		send_insn(OPC_ORA_IMM, 8'h0F, 8'hF0, 8'h00, 24'h00800F, 3'd2);
		send_insn(OPC_JMP_ABS, 8'h78, 8'h56, 8'h9A, 24'hAB1234, 3'd3);
		send_insn(OPC_JML_LONG, 8'hFF, 8'hFF, 8'hFF, 24'h123456, 3'd4);
		send_insn(OPC_JSL_LONG, 8'h00, 8'h80, 8'h01, 24'h7E0000, 3'd3);
		send_insn(OPC_BRA, 8'h80, 8'h00, 8'h00, 24'h000000, 3'd2);
		send_insn(OPC_BRL, 8'hFF, 8'h7F, 8'h00, 24'hFFFFFF, 3'd3);
		send_insn(OPC_BNE, 8'h7F, 8'h00, 8'h00, 24'hFFFFFE, 3'd4);
		send_insn(OPC_BEQ, 8'hFE, 8'h00, 8'h00, 24'h000001, 3'd2);
		send_insn(OPC_RTS, 8'h00, 8'h00, 8'h00, 24'h00C000, 3'd1);
		send_insn(OPC_JMP_IND, 8'h00, 8'hFF, 8'h00, 24'h00C001, 3'd4);
		send_insn(OPC_JSR_INDX, 8'h10, 8'h20, 8'h30, 24'h00C004, 3'd4);
		send_insn(OPC_AND_DPX, 8'h44, 8'h00, 8'h00, 24'h00C007, 3'd2);
		send_insn(OPC_WDM, 8'h00, 8'h00, 8'h00, 24'h00C009, 3'd4);
		drain_decodes();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 29;
					rx_idle_pct = 67;
				end
				1: begin
					tx_idle_pct = 67;
					rx_idle_pct = 29;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == 20 && phase != 1)
					long_hold_req = 1'b1;
				send_random_insn();
			end
			drain_decodes();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
